// ----- sv/sliding_window_avg_max_min_assert.svh -----
`ifndef SLIDING_WINDOW_AVG_MAX_MIN_ASSERT_SVH
`define SLIDING_WINDOW_AVG_MAX_MIN_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define SWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define SWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/swa_pkg.sv -----
package swa_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_W  = 9;
  localparam int AXES   = 3;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic div_start;
    logic out_load;
  } swa_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_last;
    logic div_busy;
    logic out_free;
  } swa_sts_t;

endpackage

// ----- sv/sliding_window_avg_max_min.sv -----
// An item that only fills the window is taken with no result.
// An item on a full window starts a scan of the window memory, one entry per cycle,
// then a bit-serial divide of each axis sum by the effective window length; the result
// may wait until the output is free. No new item is taken until that result is loaded.
// Reset (rst, sync): window length 1, fill count and oldest position cleared.
module sliding_window_avg_max_min import swa_pkg::*; #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample_x,
  input  logic signed [DATA_W-1:0] sample_y,
  input  logic signed [DATA_W-1:0] sample_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] max_x,
  output logic signed [DATA_W-1:0] min_x,
  output logic signed [DATA_W-1:0] avg_x,
  output logic signed [DATA_W-1:0] max_y,
  output logic signed [DATA_W-1:0] min_y,
  output logic signed [DATA_W-1:0] avg_y,
  output logic signed [DATA_W-1:0] max_z,
  output logic signed [DATA_W-1:0] min_z,
  output logic signed [DATA_W-1:0] avg_z
);

  swa_cmd_t cmd;
  swa_sts_t sts;

  swa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  swa_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sample_x  (sample_x),
    .sample_y  (sample_y),
    .sample_z  (sample_z),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .max_x     (max_x),
    .min_x     (min_x),
    .avg_x     (avg_x),
    .max_y     (max_y),
    .min_y     (min_y),
    .avg_y     (avg_y),
    .max_z     (max_z),
    .min_z     (min_z),
    .avg_z     (avg_z)
  );

endmodule

// ----- sv/swa_div.sv -----
module swa_div import swa_pkg::*; #(
  parameter int SW = 25,
  parameter int LW = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] dividend,
  input  logic [LW-1:0]        divisor,
  output logic                 busy,
  output logic [DATA_W-1:0]    quotient
);

  localparam int CW = $clog2(SW);

  logic [CW-1:0] cnt;
  logic [SW-1:0] dvd;
  logic [LW-1:0] rem;
  logic [LW-1:0] dsr;
  logic          neg;
  logic [LW:0]   shifted;
  logic [LW:0]   diff;
  logic          ge;
  logic [SW-1:0] qn;

  // restoring divide on the magnitude, one quotient bit per cycle
  always_comb begin
    shifted  = {rem, dvd[SW-1]};
    diff     = shifted - {1'b0, dsr};
    ge       = shifted >= {1'b0, dsr};
    qn       = neg ? (~dvd + SW'(1)) : dvd;
    quotient = qn[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(SW - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
      rem <= '0;
      cnt <= '0;
      neg <= dividend[SW-1];
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[SW-2:0], ge};
      rem <= ge ? diff[LW-1:0] : shifted[LW-1:0];
      cnt <= cnt + CW'(1);
    end
  end

endmodule

// ----- sv/swa_dp.sv -----
module swa_dp import swa_pkg::*; #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic signed [DATA_W-1:0] sample_x,
  input  logic signed [DATA_W-1:0] sample_y,
  input  logic signed [DATA_W-1:0] sample_z,
  input  swa_cmd_t                 cmd,
  output swa_sts_t                 sts,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] max_x,
  output logic signed [DATA_W-1:0] min_x,
  output logic signed [DATA_W-1:0] avg_x,
  output logic signed [DATA_W-1:0] max_y,
  output logic signed [DATA_W-1:0] min_y,
  output logic signed [DATA_W-1:0] avg_y,
  output logic signed [DATA_W-1:0] max_z,
  output logic signed [DATA_W-1:0] min_z,
  output logic signed [DATA_W-1:0] avg_z
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int SW = DATA_W + LW;

  logic [CFG_W-1:0]         window_length;
  logic [LW-1:0]            fill;
  logic [LW-1:0]            eff_len;
  logic [LW-1:0]            cnt;
  logic [AW-1:0]            oldest;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            wpos;
  logic [LW:0]              pos_sum;
  logic [AXES*DATA_W-1:0]   mem [MAX_WINDOW];
  logic [AXES*DATA_W-1:0]   rdata;
  logic                     rd_vld;
  logic                     rd_first;
  logic signed [DATA_W-1:0] samp [AXES];
  logic signed [DATA_W-1:0] hi [AXES];
  logic signed [DATA_W-1:0] lo [AXES];
  logic signed [SW-1:0]     sum [AXES];
  logic                     div_busy [AXES];
  logic [DATA_W-1:0]        quo [AXES];

  always_comb begin
    if (window_length == '0) begin
      eff_len = LW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(window_length);
    end
  end

  always_comb begin
    pos_sum = (LW+1)'(oldest) + (LW+1)'(fill);
    if (pos_sum >= (LW+1)'(MAX_WINDOW)) begin
      wpos = AW'(pos_sum - (LW+1)'(MAX_WINDOW));
    end else begin
      wpos = AW'(pos_sum);
    end
  end

  always_comb begin
    sts.full      = fill >= eff_len;
    sts.scan_last = cnt == (eff_len - LW'(1));
    sts.div_busy  = div_busy[0] | div_busy[1] | div_busy[2];
    sts.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_W'(1);
      fill          <= '0;
      oldest        <= '0;
      rd_vld        <= 1'b0;
      rd_first      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_data;
      end
      if (cmd.accept) begin
        if (sts.full) begin
          oldest <= (oldest == AW'(MAX_WINDOW - 1)) ? '0 : oldest + AW'(1);
        end else begin
          fill <= fill + LW'(1);
        end
      end
      rd_vld   <= cmd.scan_step;
      rd_first <= cmd.scan_step && cnt == '0;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan walks backwards from the newest entry
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      raddr <= wpos;
      cnt   <= '0;
    end else if (cmd.scan_step) begin
      raddr <= (raddr == '0) ? AW'(MAX_WINDOW - 1) : raddr - AW'(1);
      cnt   <= cnt + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wpos] <= {sample_x, sample_y, sample_z};
    end
    if (cmd.scan_step) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      samp[a] = rdata[(AXES-1-a)*DATA_W +: DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      for (int a = 0; a < AXES; a++) begin
        if (rd_first) begin
          hi[a]  <= samp[a];
          lo[a]  <= samp[a];
          sum[a] <= {{(SW-DATA_W){samp[a][DATA_W-1]}}, samp[a]};
        end else begin
          if (samp[a] > hi[a]) begin
            hi[a] <= samp[a];
          end
          if (samp[a] < lo[a]) begin
            lo[a] <= samp[a];
          end
          sum[a] <= sum[a] + {{(SW-DATA_W){samp[a][DATA_W-1]}}, samp[a]};
        end
      end
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_div
    swa_div #(
      .SW (SW),
      .LW (LW)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (sum[a]),
      .divisor  (eff_len),
      .busy     (div_busy[a]),
      .quotient (quo[a])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      max_x <= hi[0];
      min_x <= lo[0];
      avg_x <= quo[0];
      max_y <= hi[1];
      min_y <= lo[1];
      avg_y <= quo[1];
      max_z <= hi[2];
      min_z <= lo[2];
      avg_z <= quo[2];
    end
  end

endmodule

// ----- sv/swa_ctrl.sv -----
module swa_ctrl import swa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output swa_cmd_t cmd,
  input  swa_sts_t sts
);

  `include "sliding_window_avg_max_min_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.full) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SWA_ASSERT_NEXT(a_full_starts_scan, state == S_IDLE && in_valid && sts.full, state == S_SCAN, "full window transaction did not start a scan")
  `SWA_ASSERT_NEXT(a_div_started, state == S_DIVS, sts.div_busy, "divider not busy after start")
  `SWA_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free && state == S_HOLD, "result loaded over a pending one")

endmodule

// ----- dv/sliding_window_avg_max_min_checker.sv -----
module sliding_window_avg_max_min_checker import swa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample_x,
  input  logic signed [DATA_W-1:0] sample_y,
  input  logic signed [DATA_W-1:0] sample_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] max_x,
  input  logic signed [DATA_W-1:0] min_x,
  input  logic signed [DATA_W-1:0] avg_x,
  input  logic signed [DATA_W-1:0] max_y,
  input  logic signed [DATA_W-1:0] min_y,
  input  logic signed [DATA_W-1:0] avg_y,
  input  logic signed [DATA_W-1:0] max_z,
  input  logic signed [DATA_W-1:0] min_z,
  input  logic signed [DATA_W-1:0] avg_z,
  input  logic                     end_check,
  output int                       pending,
  output int                       errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = 256;

  typedef enum int {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] mean;
  } axis_stats_t;

  typedef struct packed {
    axis_stats_t x;
    axis_stats_t y;
    axis_stats_t z;
  } window_stats_t;

  sample_t          history [WINDOW_DEPTH];
  int               fill_level;
  int               oldest_slot;
  logic [CFG_W-1:0] window_length_reg;
  window_stats_t    expected_stats_q [$];
  window_stats_t    observed_stats;
  window_stats_t    wanted_stats;
  int               results_seen;
  bit               leftovers_checked;

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    leftovers_checked = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("%0t MISMATCH: %s", $time, msg);
    end
  endtask

  function automatic axis_stats_t axis_window(input axis_t axis, input int last, input int len);
    axis_stats_t              r;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
    longint                   acc;
    int                       slot;
    hi = {1'b1, {(DATA_W-1){1'b0}}};
    lo = {1'b0, {(DATA_W-1){1'b1}}};
    acc = 0;
    for (int k = 0; k < len; k++) begin
      slot = (last + WINDOW_DEPTH - k) % WINDOW_DEPTH;
      case (axis)
        AXIS_X: v = history[slot].x;
        AXIS_Y: v = history[slot].y;
        default: v = history[slot].z;
      endcase
      if (v > hi) hi = v;
      if (v < lo) lo = v;
      acc += v;
    end
    r.hi = hi;
    r.lo = lo;
    // signed division truncates toward zero
    r.mean = DATA_W'(acc / longint'(len));
    return r;
  endfunction

  task automatic absorb_sample(input sample_t s);
    int            len;
    int            slot;
    window_stats_t e;
    if (window_length_reg == 0) len = 1;
    else if (window_length_reg > WINDOW_DEPTH) len = WINDOW_DEPTH;
    else len = int'(window_length_reg);
    slot = (oldest_slot + fill_level) % WINDOW_DEPTH;
    history[slot] = s;
    if (fill_level < len) begin
      fill_level++;
    end else begin
      oldest_slot = (oldest_slot + 1) % WINDOW_DEPTH;
      e.x = axis_window(AXIS_X, slot, len);
      e.y = axis_window(AXIS_Y, slot, len);
      e.z = axis_window(AXIS_Z, slot, len);
      expected_stats_q.push_back(e);
    end
  endtask

  task automatic check_axis(input string axis_name, input axis_stats_t got,
                            input axis_stats_t want);
    if (got.hi !== want.hi)
      report_mismatch($sformatf("result %0d max_%s got %0d expected %0d",
                                results_seen, axis_name, got.hi, want.hi));
    if (got.lo !== want.lo)
      report_mismatch($sformatf("result %0d min_%s got %0d expected %0d",
                                results_seen, axis_name, got.lo, want.lo));
    if (got.mean !== want.mean)
      report_mismatch($sformatf("result %0d avg_%s got %0d expected %0d",
                                results_seen, axis_name, got.mean, want.mean));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_level = 0;
      oldest_slot = 0;
      window_length_reg = 1;
      expected_stats_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        observed_stats.x = {max_x, min_x, avg_x};
        observed_stats.y = {max_y, min_y, avg_y};
        observed_stats.z = {max_z, min_z, avg_z};
        if (expected_stats_q.size() == 0) begin
          report_mismatch("output transaction with no expected result");
        end else begin
          wanted_stats = expected_stats_q.pop_front();
          check_axis("x", observed_stats.x, wanted_stats.x);
          check_axis("y", observed_stats.y, wanted_stats.y);
          check_axis("z", observed_stats.z, wanted_stats.z);
          results_seen++;
        end
      end
      if (in_valid && !in_stall) absorb_sample({sample_x, sample_y, sample_z});
      if (cfg_we) window_length_reg = cfg_data;
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_stats_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_stats_q.size()));
      end
    end
    pending <= expected_stats_q.size();
  end

endmodule

// ----- dv/sliding_window_avg_max_min_tb.sv -----
module sliding_window_avg_max_min_tb import swa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 320;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 15;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] sample_x = '0;
  logic signed [DATA_W-1:0] sample_y = '0;
  logic signed [DATA_W-1:0] sample_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] max_x, min_x, avg_x;
  logic signed [DATA_W-1:0] max_y, min_y, avg_y;
  logic signed [DATA_W-1:0] max_z, min_z, avg_z;
  logic                     end_check = 1'b0;
  int                       pending;
  int                       errors;
  int                       gap_pct = 0;
  int                       stall_pct = 0;
  int                       cycle_count = 0;

  // long windows only after the window has been filled once; most items use short ones
  int phase_length [PHASES] = '{1, 4, 16, 0, 7, 2, 33, 256, 3, 300, 12, 511, 1, 64, 9};
  int phase_items  [PHASES] = '{120, 120, 120, 100, 120, 120, 100, 300, 120, 40, 120, 30,
                                100, 60, 120};

  sliding_window_avg_max_min dut (.*);

  sliding_window_avg_max_min_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 57;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 57;
      end
      IDLE_BOTH: begin
        gap_pct = 9;
        stall_pct = 9;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return DATA_W'($urandom_range(8)) - DATA_W'(4);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic signed [DATA_W-1:0] x, y, z);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // fill transactions give no result, so allow a full scan to finish after the last one
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_length(input int len);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= CFG_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);

    // reset length of one
    send_sample(0, 0, 0);
    send_sample(16'sh7FFF, 16'sh8000, -1);
    send_sample(16'sh8000, 16'sh7FFF, 1);
    send_sample(-1, 0, 16'sh7FFF);

    // zero length acts as one
    write_window_length(0);
    send_sample(100, -100, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);

    // grow: two fills, then negative sums truncate toward zero
    write_window_length(3);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(-3, 5, -7);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(-5, -5, -5);

    // shrink while full
    write_window_length(2);
    send_sample(7, -7, 1);
    send_sample(-1, 1, -2);

    for (int p = 0; p < PHASES; p++) begin
      write_window_length(phase_length[p]);
      set_idle(idle_mode_t'(p % 4));
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p % 5 == 2 && i == phase_items[p] / 2) wait_drained();
        send_sample(random_sample(), random_sample(), random_sample());
      end
    end

    wait_drained();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
